// ===== rtl/soe_pkg.sv =====
package soe_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int CORDIC_STEPS = 24;
  localparam int GUARD_BITS   = 20;
  localparam int EW           = 40;
  localparam int CW           = EW + GUARD_BITS + 3;
  localparam int ZW           = 34;
  localparam int PW           = 2 * SAMPLE_WIDTH;
  localparam int SW           = PW + 9;

  localparam logic [31:0] INV_GAIN_Q32 = 32'd2608131496;
  localparam logic signed [ZW-1:0] HALF_PI_UNITS = 34'sd1073741824;
  localparam logic signed [EW-1:0] E_MAX = {1'b0, {(EW-1){1'b1}}};
  localparam logic signed [EW-1:0] E_MIN = {1'b1, {(EW-1){1'b0}}};

  typedef struct packed {
    logic signed [15:0] g2_a;
    logic signed [15:0] g2_b;
    logic signed [15:0] g2_c;
    logic signed [15:0] h2_a;
    logic signed [15:0] h2_b;
    logic signed [15:0] h2_c;
    logic signed [15:0] h2_d;
  } in_word_t;

  typedef struct packed {
    logic signed [39:0] energy_dc;
    logic signed [39:0] energy_cos;
    logic signed [39:0] energy_sin;
    logic        [39:0] orient_strength;
    logic signed [15:0] orient_angle;
  } out_word_t;

  typedef struct packed {
    logic signed [EW-1:0] c1;
    logic signed [EW-1:0] c2;
    logic signed [EW-1:0] c3;
  } energy_t;

  typedef struct packed {
    logic                 zero;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    energy_t              e;
  } cordic_t;

  function automatic logic signed [ZW-1:0] atan_entry(input int i);
    logic [31:0] t;
    case (i)
      0: t = 32'h20000000;   1: t = 32'h12E4051E;   2: t = 32'h09FB385B;
      3: t = 32'h051111D4;   4: t = 32'h028B0D43;   5: t = 32'h0145D7E1;
      6: t = 32'h00A2F61E;   7: t = 32'h00517C55;   8: t = 32'h0028BE53;
      9: t = 32'h00145F2F;  10: t = 32'h000A2F98;  11: t = 32'h000517CC;
      12: t = 32'h00028BE6; 13: t = 32'h000145F3;  14: t = 32'h0000A2F9;
      15: t = 32'h0000517C; 16: t = 32'h000028BE;  17: t = 32'h0000145F;
      18: t = 32'h00000A2F; 19: t = 32'h00000517;  20: t = 32'h0000028B;
      21: t = 32'h00000145; 22: t = 32'h000000A2;  23: t = 32'h00000051;
      24: t = 32'h00000028; 25: t = 32'h00000014;  26: t = 32'h0000000A;
      27: t = 32'h00000005; 28: t = 32'h00000002;  29: t = 32'h00000001;
      default: t = 32'h0;
    endcase
    return signed'({2'b00, t});
  endfunction

endpackage

// ===== rtl/soe_energy.sv =====
module soe_energy (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  soe_pkg::in_word_t  in_word,
  output logic               out_valid,
  output soe_pkg::energy_t   out_energy
);
  import soe_pkg::*;

  typedef logic signed [SAMPLE_WIDTH-1:0] smp_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [SW-1:0] sum_t;

  smp_t ga, gb, gc, ha, hb, hc, hd;
  prod_t p [16];
  logic  v1, v2;
  sum_t  s1, s2, s3;

  assign ga = in_word.g2_a[SAMPLE_WIDTH-1:0];
  assign gb = in_word.g2_b[SAMPLE_WIDTH-1:0];
  assign gc = in_word.g2_c[SAMPLE_WIDTH-1:0];
  assign ha = in_word.h2_a[SAMPLE_WIDTH-1:0];
  assign hb = in_word.h2_b[SAMPLE_WIDTH-1:0];
  assign hc = in_word.h2_c[SAMPLE_WIDTH-1:0];
  assign hd = in_word.h2_d[SAMPLE_WIDTH-1:0];

  // stage 1: pairwise products
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= in_valid;
    p[0]  <= ga * ga; p[1]  <= gb * gb; p[2]  <= gc * gc; p[3]  <= ga * gc;
    p[4]  <= ha * ha; p[5]  <= hb * hb; p[6]  <= hc * hc; p[7]  <= hd * hd;
    p[8]  <= ha * hc; p[9]  <= hb * hd; p[10] <= ga * gb; p[11] <= gb * gc;
    p[12] <= hc * hd; p[13] <= ha * hb; p[14] <= hb * hc; p[15] <= ha * hd;
  end

  function automatic sum_t ex(input prod_t v);
    return sum_t'(v);
  endfunction

  function automatic logic signed [EW-1:0] sat(input sum_t v);
    if (v > sum_t'(E_MAX)) return E_MAX;
    if (v < sum_t'(E_MIN)) return E_MIN;
    return v[EW-1:0];
  endfunction

  // stage 2: weighted sums by shift and add
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
    s1 <= 16 * ex(p[1]) + 8 * ex(p[3]) + 12 * (ex(p[0]) + ex(p[2]))
        + 10 * (ex(p[4]) + ex(p[7])) + 18 * (ex(p[5]) + ex(p[6]))
        + 12 * (ex(p[8]) + ex(p[9]));
    s2 <= 16 * (ex(p[0]) - ex(p[2])) + 15 * (ex(p[4]) - ex(p[7]))
        + 9 * (ex(p[5]) - ex(p[6])) + 6 * (ex(p[8]) - ex(p[9]));
    s3 <= -32 * ex(p[10]) - 32 * ex(p[11]) - 30 * (ex(p[12]) + ex(p[13]))
        - 54 * ex(p[14]) - 6 * ex(p[15]);
  end

  assign out_valid     = v2;
  assign out_energy.c1 = sat(s1);
  assign out_energy.c2 = sat(s2);
  assign out_energy.c3 = sat(s3);
endmodule

// ===== rtl/soe_cordic.sv =====
module soe_cordic (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  soe_pkg::energy_t  in_energy,
  output logic              out_valid,
  output soe_pkg::cordic_t  out_cordic
);
  import soe_pkg::*;

  cordic_t st [CORDIC_STEPS+1];
  logic    v  [CORDIC_STEPS+1];
  cordic_t pre;
  logic signed [CW-1:0] x0, y0;

  always_comb begin
    x0 = CW'(in_energy.c2) <<< GUARD_BITS;
    y0 = CW'(in_energy.c3) <<< GUARD_BITS;
    pre.e    = in_energy;
    pre.zero = (in_energy.c2 == '0) && (in_energy.c3 == '0);
    if (x0 < 0) begin
      if (y0 >= 0) begin
        pre.x = y0;  pre.y = -x0; pre.z = HALF_PI_UNITS;
      end else begin
        pre.x = -y0; pre.y = x0;  pre.z = -HALF_PI_UNITS;
      end
    end else begin
      pre.x = x0; pre.y = y0; pre.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v[0] <= 1'b0;
    else     v[0] <= in_valid;
    st[0] <= pre;
  end

  // one rotation per stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam int SH = (i < CW - 1) ? i : CW - 1;
    always_ff @(posedge clk) begin
      if (rst) v[i+1] <= 1'b0;
      else     v[i+1] <= v[i];
      st[i+1].zero <= st[i].zero;
      st[i+1].e    <= st[i].e;
      if (st[i].y >= 0) begin
        st[i+1].x <= st[i].x + (st[i].y >>> SH);
        st[i+1].y <= st[i].y - (st[i].x >>> SH);
        st[i+1].z <= st[i].z + atan_entry(i);
      end else begin
        st[i+1].x <= st[i].x - (st[i].y >>> SH);
        st[i+1].y <= st[i].y + (st[i].x >>> SH);
        st[i+1].z <= st[i].z - atan_entry(i);
      end
    end
  end

  assign out_valid  = v[CORDIC_STEPS];
  assign out_cordic = st[CORDIC_STEPS];
endmodule

// ===== rtl/soe_post.sv =====
module soe_post (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  soe_pkg::cordic_t   in_cordic,
  output logic               out_valid,
  output soe_pkg::out_word_t out_word
);
  import soe_pkg::*;

  localparam int UW = CW - 1;

  logic [UW-1:0] ux;
  logic [31:0]   hi, lo;
  logic          v1, v2;
  logic [63:0]   ph, pl;
  energy_t       e1;
  logic          z1;
  logic signed [15:0] ang1;
  logic signed [ZW-1:0] zr;
  logic [64:0]   q;
  logic [64:0]   m;

  always_comb begin
    ux = (in_cordic.x > 0) ? in_cordic.x[UW-1:0] : '0;
    hi = 32'(ux >> 32);
    lo = ux[31:0];
    zr = (in_cordic.z + ZW'(65536)) >>> 17;
  end

  // stage 1: gain products, angle folding
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= in_valid;
    ph <= hi * INV_GAIN_Q32;
    pl <= lo * INV_GAIN_Q32;
    e1 <= in_cordic.e;
    z1 <= in_cordic.zero;
    if (zr <= -16384)    ang1 <= 16'(zr + 32768);
    else if (zr > 16384) ang1 <= 16'(zr - 32768);
    else                 ang1 <= zr[15:0];
  end

  always_comb begin
    q = {1'b0, ph} + 65'(pl >> 32);
    m = (q + 65'(1 << (GUARD_BITS - 1))) >> GUARD_BITS;
  end

  // stage 2: rounding, cap, output register
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
    out_word.energy_dc  <= e1.c1;
    out_word.energy_cos <= e1.c2;
    out_word.energy_sin <= e1.c3;
    if (z1) begin
      out_word.orient_strength <= '0;
      out_word.orient_angle    <= '0;
    end else begin
      out_word.orient_strength <= (m > 65'({EW{1'b1}})) ? {EW{1'b1}} : m[EW-1:0];
      out_word.orient_angle    <= ang1;
    end
  end

  assign out_valid = v2;
endmodule

// ===== rtl/steerable_oriented_energy.sv =====
// Steerable G2/H2 oriented energy, one pixel word per clock.
// Input: start with the seven basis responses on in_word; taken when start
// is high and busy is low. busy is held low: a word can enter every cycle.
// Output: done strobes for one cycle with result; it must be taken then,
// as the receiver cannot stall the pipe.
// Pipeline from start to done: products and weighted sums in soe_energy,
// the CORDIC pre-rotation register, one register per CORDIC rotation, then
// gain correction and rounding in soe_post.
// Throughput: one word per cycle, set by the fully unrolled rotation chain.
// Reset clears all valid bits; words in flight are dropped and no strobe
// follows until new words enter.
module steerable_oriented_energy (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  soe_pkg::in_word_t  in_word,
  output logic               done,
  output soe_pkg::out_word_t result
);
  import soe_pkg::*;

  logic    ev, cv;
  energy_t en;
  cordic_t cr;

  assign busy = 1'b0;

  soe_energy u_energy (.clk, .rst, .in_valid(start), .in_word,
                       .out_valid(ev), .out_energy(en));
  soe_cordic u_cordic (.clk, .rst, .in_valid(ev), .in_energy(en),
                       .out_valid(cv), .out_cordic(cr));
  soe_post   u_post   (.clk, .rst, .in_valid(cv), .in_cordic(cr),
                       .out_valid(done), .out_word(result));

  a_lat: assert property (@(posedge clk) disable iff (rst)
    ev |-> ##(CORDIC_STEPS + 3) done)
    else $error("energy word lost in pipe");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.energy_cos == '0 && result.energy_sin == '0 |->
      result.orient_strength == '0 && result.orient_angle == '0)
    else $error("zero vector gave nonzero orientation");
  a_ang: assert property (@(posedge clk) disable iff (rst)
    done |-> result.orient_angle > -16'sd16384 && result.orient_angle <= 16'sd16384)
    else $error("angle out of range");
endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import soe_pkg::*;

  localparam int LATENCY = CORDIC_STEPS + 5;
  localparam int IDLE_LIMIT = 2000;
  localparam int N_RANDOM = 1830;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  in_word_t in_word = '0;
  out_word_t result;

  in_word_t pixel_q[$];
  out_word_t energy_q[$];
  int errors = 0;
  int n_words = 0;
  int n_results = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;
  bit stim_done = 1'b0;
  int burst_left = 0;
  int gap_left = 0;

  steerable_oriented_energy dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .in_word(in_word), .done(done), .result(result)
  );

  always #6 clk = ~clk;

  function automatic longint floor_shr(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint clamp40(input longint v);
    if (v > 64'sd549755813887) return 64'sd549755813887;
    if (v < -64'sd549755813888) return -64'sd549755813888;
    return v;
  endfunction

  function automatic longint arctan_step(input int i);
    case (i)
      0: return 64'h20000000;   1: return 64'h12E4051E;   2: return 64'h09FB385B;
      3: return 64'h051111D4;   4: return 64'h028B0D43;   5: return 64'h0145D7E1;
      6: return 64'h00A2F61E;   7: return 64'h00517C55;   8: return 64'h0028BE53;
      9: return 64'h00145F2F;  10: return 64'h000A2F98;  11: return 64'h000517CC;
      12: return 64'h00028BE6; 13: return 64'h000145F3;  14: return 64'h0000A2F9;
      15: return 64'h0000517C; 16: return 64'h000028BE;  17: return 64'h0000145F;
      18: return 64'h00000A2F; 19: return 64'h00000517;  20: return 64'h0000028B;
      21: return 64'h00000145; 22: return 64'h000000A2;  23: return 64'h00000051;
      24: return 64'h00000028; 25: return 64'h00000014;  26: return 64'h0000000A;
      27: return 64'h00000005; 28: return 64'h00000002;  29: return 64'h00000001;
      default: return 64'h0;
    endcase
  endfunction

  function automatic out_word_t oriented_energy(input in_word_t p);
    longint ga, gb, gc, ha, hb, hc, hd, c1, c2, c3, x, y, z, nx, ny, ang;
    logic [63:0] ux, q, mag;
    out_word_t r;
    ga = p.g2_a; gb = p.g2_b; gc = p.g2_c;
    ha = p.h2_a; hb = p.h2_b; hc = p.h2_c; hd = p.h2_d;
    c1 = 16*gb*gb + 8*ga*gc + 12*(ga*ga + gc*gc) + 10*(ha*ha + hd*hd)
       + 18*(hb*hb + hc*hc) + 12*(ha*hc + hb*hd);
    c2 = 16*(ga*ga - gc*gc) + 15*(ha*ha - hd*hd) + 9*(hb*hb - hc*hc)
       + 6*(ha*hc - hb*hd);
    c3 = -32*ga*gb - 32*gb*gc - 30*(hc*hd + ha*hb) - 54*hb*hc - 6*ha*hd;
    c1 = clamp40(c1); c2 = clamp40(c2); c3 = clamp40(c3);
    mag = 0;
    ang = 0;
    if (c2 != 0 || c3 != 0) begin
      x = c2 <<< GUARD_BITS;
      y = c3 <<< GUARD_BITS;
      z = 0;
      if (x < 0) begin
        if (y >= 0) begin
          nx = y; ny = -x; z = 64'sd1073741824;
        end else begin
          nx = -y; ny = x; z = -64'sd1073741824;
        end
        x = nx; y = ny;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        if (y >= 0) begin
          nx = x + floor_shr(y, i); ny = y - floor_shr(x, i); z += arctan_step(i);
        end else begin
          nx = x - floor_shr(y, i); ny = y + floor_shr(x, i); z -= arctan_step(i);
        end
        x = nx; y = ny;
      end
      ux = (x > 0) ? x : 0;
      q = (ux >> 32) * 64'd2608131496 + (((ux & 64'hFFFFFFFF) * 64'd2608131496) >> 32);
      mag = (q + (64'd1 << (GUARD_BITS - 1))) >> GUARD_BITS;
      if (mag > 64'hFF_FFFF_FFFF) mag = 64'hFF_FFFF_FFFF;
      ang = floor_shr(z + 65536, 17);
      if (ang <= -16384) ang += 32768;
      if (ang > 16384) ang -= 32768;
    end
    r.energy_dc = c1[39:0];
    r.energy_cos = c2[39:0];
    r.energy_sin = c3[39:0];
    r.orient_strength = mag[39:0];
    r.orient_angle = ang[15:0];
    return r;
  endfunction

  function automatic logic [15:0] pick_sample(input int mode);
    case (mode)
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'(($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  // fields mostly full range, some extremes and small values
  function automatic in_word_t random_pixel();
    in_word_t p;
    int m;
    m = $urandom_range(0, 9);
    p.g2_a = pick_sample(m < 6 ? 4 : $urandom_range(0, 4));
    p.g2_b = pick_sample(m < 6 ? 4 : $urandom_range(0, 4));
    p.g2_c = pick_sample(m < 6 ? 4 : $urandom_range(0, 4));
    p.h2_a = pick_sample(m < 6 ? 4 : $urandom_range(0, 4));
    p.h2_b = pick_sample(m < 6 ? 4 : $urandom_range(0, 4));
    p.h2_c = pick_sample(m < 6 ? 4 : $urandom_range(0, 4));
    p.h2_d = pick_sample(m < 6 ? 4 : $urandom_range(0, 4));
    return p;
  endfunction

  initial begin
    in_word_t p;
    p = '0; pixel_q.push_back(p);                                 // zero vector
    p = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
    pixel_q.push_back(p);
    p = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
    pixel_q.push_back(p);
    p = '{16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000};
    pixel_q.push_back(p);
    p = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF};
    pixel_q.push_back(p);
    p = '0; p.g2_a = 100; pixel_q.push_back(p);                   // c2 > 0, c3 = 0
    p = '0; p.g2_c = 100; pixel_q.push_back(p);                   // c2 < 0, c3 = 0
    p = '0; p.g2_a = 5; p.g2_b = -5; p.g2_c = 5; pixel_q.push_back(p);
    p = '0; p.g2_a = 5; p.g2_b = 5; p.g2_c = 5; pixel_q.push_back(p);
    p = '0; p.h2_b = 1; p.h2_c = 1; pixel_q.push_back(p);
    p = '0; p.h2_a = -1; p.h2_d = 1; pixel_q.push_back(p);
    p = '0; p.g2_b = 16'sh8000; p.h2_d = 16'sh8000; pixel_q.push_back(p);
    p = '0; p.g2_a = 1; pixel_q.push_back(p);
    p = '0; p.g2_c = 1; p.g2_b = -1; pixel_q.push_back(p);
    p = '0; p.h2_a = 16'sh7FFF; p.h2_b = 16'sh8000; pixel_q.push_back(p);
    p = '0; p.h2_c = 16'sh7FFF; p.h2_d = 16'sh7FFF; pixel_q.push_back(p);
    for (int i = 0; i < N_RANDOM; i++) begin
      pixel_q.push_back(random_pixel());
      if (i == N_RANDOM / 2) begin
        wait (pixel_q.size() == 0 && !start && energy_q.size() == 0);
        hold_off = 1'b1;
        repeat (LATENCY + 3) @(posedge clk);
        hold_off = 1'b0;
      end
    end
    stim_done = 1'b1;
  end

  // sender: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        energy_q.push_back(oriented_energy(in_word));
        n_words++;
      end
      if (start && busy) begin
        // word still waiting
      end else if (gap_left > 0 || hold_off || pixel_q.size() == 0) begin
        if (gap_left > 0) gap_left--;
        start <= 1'b0;
      end else begin
        in_word <= pixel_q.pop_front();
        start <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      n_results++;
      if (energy_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word %h", $time, result);
      end else begin
        out_word_t e;
        e = energy_q.pop_front();
        if (e.energy_dc !== result.energy_dc)
          $display("%0t: energy_dc exp %0d got %0d", $time, e.energy_dc, result.energy_dc);
        if (e.energy_cos !== result.energy_cos)
          $display("%0t: energy_cos exp %0d got %0d", $time, e.energy_cos, result.energy_cos);
        if (e.energy_sin !== result.energy_sin)
          $display("%0t: energy_sin exp %0d got %0d", $time, e.energy_sin, result.energy_sin);
        if (e.orient_strength !== result.orient_strength)
          $display("%0t: orient_strength exp %0d got %0d", $time, e.orient_strength,
                   result.orient_strength);
        if (e.orient_angle !== result.orient_angle)
          $display("%0t: orient_angle exp %0d got %0d", $time, e.orient_angle,
                   result.orient_angle);
        if (e !== result) errors++;
      end
    end
  end

  // watchdog on cycles with no word moving either way
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || hold_off) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    wait (stim_done && pixel_q.size() == 0 && !start && energy_q.size() == 0);
    repeat (LATENCY + 5) @(posedge clk);
    $display("covered %0d pixel words, %0d results, extremes and zero vector included",
             n_words, n_results);
    if (errors == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule
